FILE: src/u8v_pkg.sv
`timescale 1ns / 1ps

package u8v_pkg;

   // widths fixed by the field definitions
   localparam int DATA_W      = 8;
   localparam int CFG_W       = 16;
   localparam int COUNT_W     = 17;
   localparam int CP_W        = 21;
   localparam int PEND_W      = 2;
   localparam int CSR_INDEX_W = 1;

   // default for the length parameter of the top level
   localparam int LENGTH_WIDTH_DEF = 16;

   // register reset values
   localparam logic [CFG_W-1:0] MAX_LENGTH_RST = CFG_W'(255);
   localparam logic             EMPTY_OK_RST   = 1'b0;

   // register indexes on the control port
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EMPTY_OK   = 1'b1;

   // byte classes
   localparam logic [DATA_W-1:0] ASCII_MAX    = 8'h7f;
   localparam logic [DATA_W-1:0] LEAD2_MASK   = 8'he0;
   localparam logic [DATA_W-1:0] LEAD2_CODE   = 8'hc0;
   localparam logic [DATA_W-1:0] LEAD3_MASK   = 8'hf0;
   localparam logic [DATA_W-1:0] LEAD3_CODE   = 8'he0;
   localparam logic [DATA_W-1:0] LEAD4_MASK   = 8'hf8;
   localparam logic [DATA_W-1:0] LEAD4_CODE   = 8'hf0;
   localparam logic [DATA_W-1:0] CONT_MASK    = 8'hc0;
   localparam logic [DATA_W-1:0] CONT_CODE    = 8'h80;

   // code point limits
   localparam logic [CP_W-1:0] MIN_CP2   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_CP3   = 21'h000800;
   localparam logic [CP_W-1:0] MIN_CP4   = 21'h010000;
   localparam logic [CP_W-1:0] MAX_CP    = 21'h10ffff;
   localparam logic [CP_W-1:0] SURR_LO   = 21'h00d800;
   localparam logic [CP_W-1:0] SURR_HI   = 21'h00dfff;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              is_last;
      logic              empty_string;
   } req_type;

   typedef struct packed {
      logic               valid_res;
      logic [COUNT_W-1:0] byte_count;
   } rsp_type;

   // per-string decode state
   typedef struct packed {
      logic [PEND_W-1:0]  bytes_pending;
      logic [PEND_W-1:0]  sequence_length;
      logic [CP_W-1:0]    code_point_acc;
      logic               error_seen;
      logic [COUNT_W-1:0] length_count;
   } str_state_type;

endpackage

FILE: src/u8v_step.sv
`timescale 1ns / 1ps

module u8v_step import u8v_pkg::*; #(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
   input  str_state_type    str_cur,
   input  req_type          item,
   input  logic [CFG_W-1:0] max_length,
   input  logic             empty_ok,
   output str_state_type    str_nxt,
   output rsp_type          rsp,
   output logic             ends_string
);

   localparam int USED_W = (LENGTH_WIDTH < CFG_W) ? LENGTH_WIDTH : CFG_W;

   logic [COUNT_W-1:0] limit;
   logic [DATA_W-1:0]  b;
   logic [CP_W-1:0]    cp;
   logic               cp_bad;
   str_state_type      upd;

   assign limit = COUNT_W'(max_length[USED_W-1:0]);
   assign b     = item.data_byte;

   // code point once the current continuation byte is folded in
   assign cp = {str_cur.code_point_acc[CP_W-7:0], b[5:0]};

   // overlong, out of range or surrogate
   always_comb begin
      cp_bad = (cp > MAX_CP) || ((cp >= SURR_LO) && (cp <= SURR_HI));
      unique case (str_cur.sequence_length)
         2'd1:    cp_bad = cp_bad || (cp < MIN_CP2);
         2'd2:    cp_bad = cp_bad || (cp < MIN_CP3);
         2'd3:    cp_bad = cp_bad || (cp < MIN_CP4);
         default: cp_bad = cp_bad;
      endcase
   end

   // state after taking one byte
   always_comb begin
      upd = str_cur;
      if (str_cur.length_count <= limit) begin
         upd.length_count = str_cur.length_count + COUNT_W'(1);
      end
      if (b == '0) begin
         upd.error_seen = 1'b1;
      end
      if (str_cur.bytes_pending == '0) begin
         priority if (b <= ASCII_MAX) begin
            upd.bytes_pending = '0;
         end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            upd.bytes_pending   = 2'd1;
            upd.sequence_length = 2'd1;
            upd.code_point_acc  = CP_W'(b[4:0]);
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            upd.bytes_pending   = 2'd2;
            upd.sequence_length = 2'd2;
            upd.code_point_acc  = CP_W'(b[3:0]);
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            upd.bytes_pending   = 2'd3;
            upd.sequence_length = 2'd3;
            upd.code_point_acc  = CP_W'(b[2:0]);
         end else begin
            upd.error_seen = 1'b1;
         end
      end else if ((b & CONT_MASK) != CONT_CODE) begin
         // broken sequence is dropped
         upd.error_seen      = 1'b1;
         upd.bytes_pending   = '0;
         upd.sequence_length = '0;
         upd.code_point_acc  = '0;
      end else if (str_cur.bytes_pending == 2'd1) begin
         // sequence complete
         upd.error_seen      = upd.error_seen || cp_bad;
         upd.bytes_pending   = '0;
         upd.sequence_length = '0;
         upd.code_point_acc  = '0;
      end else begin
         upd.bytes_pending  = str_cur.bytes_pending - 2'd1;
         upd.code_point_acc = cp;
      end
   end

   // verdict and next state
   always_comb begin
      ends_string = item.empty_string || item.is_last;
      if (item.empty_string) begin
         if (str_cur.length_count == '0) begin
            rsp.valid_res = empty_ok;
         end else begin
            rsp.valid_res = !str_cur.error_seen && (str_cur.bytes_pending == '0)
                            && (str_cur.length_count <= limit);
         end
         rsp.byte_count = str_cur.length_count;
      end else begin
         rsp.valid_res = !upd.error_seen && (upd.bytes_pending == '0)
                         && (upd.length_count <= limit);
         rsp.byte_count = upd.length_count;
      end
      if (ends_string) begin
         str_nxt = '0;
      end else begin
         str_nxt = upd;
      end
   end

endmodule

FILE: src/utf8_string_validator_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_type: data_byte, is_last, empty_string
// rsp_      out        rsp_valid/rsp_stall  rsp_type: valid_res, byte_count
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One byte per cycle while req_stall is low: a byte is registered, decoded by one
// short step of logic and, if it ends the string, its verdict is loaded into the
// result register, which drives rsp_ after the input register has held the byte.
// Synchronous active-high reset clears the handshake and string state and
// restores the register defaults. A stall on rsp_ holds the result register;
// req_stall rises only when a verdict cannot leave the decode stage.

module utf8_string_validator_unit import u8v_pkg::*; #(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   logic [CFG_W-1:0] max_len_ff;
   logic             empty_ok_ff;

   logic             in_valid_ff;
   req_type          in_data_ff;
   logic             out_valid_ff;
   rsp_type          out_data_ff;
   str_state_type    str_ff;

   str_state_type    str_in;
   rsp_type          step_rsp;
   logic             step_ends;
   logic             out_free;
   logic             advance;
   logic             req_xfer;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= MAX_LENGTH_RST;
         empty_ok_ff <= EMPTY_OK_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_LENGTH: max_len_ff  <= csr_wdata;
            CSR_EMPTY_OK:   empty_ok_ff <= csr_wdata[0];
            default:        max_len_ff  <= max_len_ff;
         endcase
      end
   end

   // decode step
   u8v_step #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_step (
      .str_cur    (str_ff),
      .item       (in_data_ff),
      .max_length (max_len_ff),
      .empty_ok   (empty_ok_ff),
      .str_nxt    (str_in),
      .rsp        (step_rsp),
      .ends_string(step_ends)
   );

   // flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!step_ends || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
   end

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         str_ff <= '0;
      end else if (advance) begin
         str_ff <= str_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_ends) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_ends) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   // a verdict leaves the string state cleared
   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (advance && step_ends) |=> (str_ff == '0))
      else $error("string state not cleared after verdict");

   // pending bytes never exceed the sequence they belong to
   a_pending_in_seq: assert property (@(posedge clock) disable iff (reset)
      str_ff.bytes_pending <= str_ff.sequence_length)
      else $error("pending count beyond sequence length");

   // no partial code point outside a sequence
   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      (str_ff.bytes_pending == '0) |-> (str_ff.code_point_acc == '0))
      else $error("code point accumulator dirty between sequences");

   // a held verdict in the decode stage is the only source of back-pressure
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked verdict");
`endif

endmodule
